[hdl/nbgs_pkg.sv]
// Shared types, codes and constants of the n-body gravity step core.
package nbgs_pkg;

   localparam int MAX_BODIES = 64;
   localparam int IDW        = $clog2(MAX_BODIES);
   localparam int CSR_W      = 32;
   localparam int CSR_IW     = 3;
   localparam int SQRT_STEPS = 33;

   typedef enum logic [0:0] {
      CMD_ADD  = 1'b0,
      CMD_STEP = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OCCUPIED = 2'd1,
      ST_NO_BODY  = 2'd2
   } status_type;

   localparam logic [CSR_IW-1:0] CSR_GRAV   = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_DT     = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_LEFT   = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_TOP    = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_RIGHT  = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_BOTTOM = 3'd5;

   localparam logic [31:0]        GRAV_RESET   = 32'd1230876000;
   localparam logic [7:0]         DT_RESET     = 8'd10;
   localparam logic signed [15:0] LEFT_RESET   = 16'sd0;
   localparam logic signed [15:0] TOP_RESET    = 16'sd0;
   localparam logic signed [15:0] RIGHT_RESET  = 16'sd1024;
   localparam logic signed [15:0] BOTTOM_RESET = 16'sd768;

   typedef enum logic [4:0] {
      S_IDLE, S_ADD_RSP, S_SELF, S_SCAN, S_PAIR, S_SQ_X, S_SQ_Y, S_SQRT,
      S_GM_LO, S_GM_HI, S_T_GO, S_T_WT, S_A_GO, S_A_WT,
      S_MX_LO, S_MX_HI, S_CX_GO, S_CX_WT, S_MY_LO, S_MY_HI, S_CY_GO, S_CY_WT,
      S_FIN_V, S_FIN_P, S_WB
   } state_type;

   typedef struct packed {
      logic [39:0]        mass;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [47:0] vel_x;
      logic signed [47:0] vel_y;
      logic [15:0]        life;
      logic [31:0]        owner;
   } body_type;

endpackage

[hdl/nbgs_ram.sv]
// Generic single-port-write, registered-read RAM.
module nbgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/nbgs_div.sv]
// Bit-serial saturating divider: 96-bit dividend over 33-bit divisor, 64-bit quotient.
module nbgs_div import nbgs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [31:0] num_hi,
   input  logic [63:0] num_lo,
   input  logic [32:0] den,
   output logic        done,
   output logic [63:0] quo
);

   logic [32:0] rem_ff, rem_in;
   logic [63:0] num_ff, num_in;
   logic [63:0] quo_ff, quo_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [33:0] sh;
   logic        ge;

   always_comb begin
      sh      = {rem_ff, num_ff[63]};
      ge      = sh >= {1'b0, den};
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         // quotient would not fit: saturate at once
         if ({1'b0, num_hi} >= den) begin
            quo_in  = '1;
            done_in = 1'b1;
         end else begin
            rem_in = {1'b0, num_hi};
            num_in = num_lo;
            cnt_in = 7'd0;
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         rem_in = ge ? 33'(sh - {1'b0, den}) : sh[32:0];
         num_in = {num_ff[62:0], 1'b0};
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

[hdl/nbody_gravity_step_core.sv]
// Top level: body table, sequencer and shared multiply/root/divide datapath.
// Add: a free slot answers in the cycle after start and takes no busy time; an occupied
// slot answers from S_ADD_RSP. A step of an empty slot answers NO_BODY with no busy time;
// else it scans every slot and, per other valid body, uses one 32x32 multiplier, a
// 33-step square root and four 64-step divisions. One at a time; busy is high meanwhile.
// Results are strobed for one cycle. Reset clears valid bits and sequencer, presets CSRs.
module nbody_gravity_step_core import nbgs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_cmd,
   input  logic [5:0]               req_body_id,
   input  logic [31:0]              req_owner_id,
   input  logic [39:0]              req_mass,
   input  logic signed [31:0]       req_pos_x,
   input  logic signed [31:0]       req_pos_y,
   input  logic signed [47:0]       req_vel_x,
   input  logic signed [47:0]       req_vel_y,
   input  logic [15:0]              req_life,
   output logic                     rsp_valid,
   output logic [5:0]               rsp_out_body_id,
   output logic signed [31:0]       rsp_out_pos_x,
   output logic signed [31:0]       rsp_out_pos_y,
   output logic signed [47:0]       rsp_out_vel_x,
   output logic signed [47:0]       rsp_out_vel_y,
   output logic                     rsp_alive,
   output logic [31:0]              rsp_dead_owner,
   output logic [1:0]               rsp_status,
   input  logic                     csr_we,
   input  logic [CSR_IW-1:0]        csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   localparam logic [63:0]        ACC_LIM_U = 64'h0040_0000_0000_0000;
   localparam logic signed [56:0] ACC_LIM   = 57'sh40_0000_0000_0000;
   localparam logic signed [65:0] V_MAX     = 66'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [65:0] V_MIN     = -66'sh0_8000_0000_0000;
   localparam logic signed [33:0] P_MAX     = 34'sh0_7FFF_FFFF;
   localparam logic signed [33:0] P_MIN     = -34'sh0_8000_0000;

   function automatic logic signed [55:0] acc_add(input logic signed [55:0] acc,
                                                  input logic neg, input logic [63:0] q);
      logic signed [56:0] c;
      logic signed [56:0] s;
      c = (q > ACC_LIM_U) ? ACC_LIM : $signed({2'b00, q[54:0]});
      if (neg) begin
         c = -c;
      end
      s = $signed({acc[55], acc}) + c;
      if (s > ACC_LIM) begin
         s = ACC_LIM;
      end else if (s < -ACC_LIM) begin
         s = -ACC_LIM;
      end
      return s[55:0];
   endfunction

   // configuration
   logic [31:0]        grav_ff;
   logic [7:0]         dt_ff;
   logic signed [15:0] left_ff, top_ff, right_ff, bottom_ff;

   state_type state_ff, state_in;
   logic [MAX_BODIES-1:0] valid_ff, valid_in;
   logic [IDW-1:0] id_ff, id_in;
   logic [IDW:0]   j_ff, j_in;

   // the stepped body
   logic signed [31:0] spx_ff, spx_in, spy_ff, spy_in;
   logic signed [47:0] svx_ff, svx_in, svy_ff, svy_in;
   logic [15:0]        life_ff, life_in;
   logic [31:0]        owner_ff, owner_in;
   logic [39:0]        smass_ff, smass_in;

   // the other body of the pair
   logic [31:0] adx_ff, adx_in, ady_ff, ady_in;
   logic        negx_ff, negx_in, negy_ff, negy_in;
   logic [39:0] mass_ff, mass_in;

   logic [65:0] rad_ff, rad_in;
   logic [35:0] srem_ff, srem_in;
   logic [32:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [40:0] gm_ff, gm_in;
   logic [63:0] a_ff, a_in;
   logic [95:0] pp_ff, pp_in;
   logic signed [55:0] ax_ff, ax_in, ay_ff, ay_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [5:0]         rid_ff, rid_in;
   logic signed [31:0] rpx_ff, rpx_in, rpy_ff, rpy_in;
   logic signed [47:0] rvx_ff, rvx_in, rvy_ff, rvy_in;
   logic               ralive_ff, ralive_in;
   logic [31:0]        rowner_ff, rowner_in;
   logic [1:0]         rstat_ff, rstat_in;

   // memory and units
   body_type       rd_data, wr_data;
   logic           wr_en;
   logic [IDW-1:0] raddr, waddr;
   logic           div_go, div_done;
   logic [31:0]    div_hi;
   logic [63:0]    div_lo, div_q;
   logic [31:0]    mul_a, mul_b;
   logic [63:0]    mul_p;

   // combinational helpers
   logic signed [32:0] dx, dy;
   logic [35:0]        sq_sh, sq_trial;
   logic signed [64:0] avx, avy;
   logic signed [65:0] vsx, vsy;
   logic signed [56:0] pvx, pvy;
   logic signed [33:0] psx, psy;
   logic               req_valid, scan_hit, dead;

   nbgs_ram #(.WIDTH($bits(body_type)), .DEPTH(MAX_BODIES)) u_ram (
      .clock(clock), .we(wr_en), .waddr(waddr), .wdata(wr_data),
      .raddr(raddr), .rdata(rd_data)
   );

   nbgs_div u_div (
      .clock(clock), .reset(reset), .go(div_go), .num_hi(div_hi), .num_lo(div_lo),
      .den(root_ff), .done(div_done), .quo(div_q)
   );

   assign mul_p     = mul_a * mul_b;
   assign req_valid = valid_ff[req_body_id];
   assign scan_hit  = valid_ff[j_ff[IDW-1:0]] && (j_ff[IDW-1:0] != id_ff);

   always_comb begin
      dx       = $signed({rd_data.pos_x[31], rd_data.pos_x}) - $signed({spx_ff[31], spx_ff});
      dy       = $signed({rd_data.pos_y[31], rd_data.pos_y}) - $signed({spy_ff[31], spy_ff});
      sq_sh    = {srem_ff[33:0], rad_ff[65:64]};
      sq_trial = {1'b0, root_ff, 2'b01};
      avx      = ax_ff * $signed({1'b0, dt_ff});
      avy      = ay_ff * $signed({1'b0, dt_ff});
      vsx      = $signed({{18{svx_ff[47]}}, svx_ff}) + $signed({avx[64], avx});
      vsy      = $signed({{18{svy_ff[47]}}, svy_ff}) + $signed({avy[64], avy});
      pvx      = svx_ff * $signed({1'b0, dt_ff});
      pvy      = svy_ff * $signed({1'b0, dt_ff});
      psx      = $signed({{2{spx_ff[31]}}, spx_ff}) + $signed({pvx[56], pvx[56:24]});
      psy      = $signed({{2{spy_ff[31]}}, spy_ff}) + $signed({pvy[56], pvy[56:24]});
      dead     = (life_ff == 16'd0)
              || (spx_ff >= $signed({right_ff, 16'h0000}))
              || (spy_ff <= $signed({top_ff, 16'h0000}))
              || (spx_ff <= $signed({left_ff, 16'h0000}))
              || (spy_ff >= $signed({bottom_ff, 16'h0000}));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start && req_valid) begin
               state_in = (req_cmd == CMD_ADD) ? S_ADD_RSP : S_SELF;
            end
         end
         S_ADD_RSP: state_in = S_IDLE;
         S_SELF:    state_in = S_SCAN;
         S_SCAN: begin
            if (j_ff == (IDW+1)'(MAX_BODIES)) begin
               state_in = S_FIN_V;
            end else if (scan_hit) begin
               state_in = S_PAIR;
            end
         end
         S_PAIR:  state_in = (dx == 33'sd0 && dy == 33'sd0) ? S_SCAN : S_SQ_X;
         S_SQ_X:  state_in = S_SQ_Y;
         S_SQ_Y:  state_in = S_SQRT;
         S_SQRT:  state_in = (cnt_ff == 6'(SQRT_STEPS - 1)) ? S_GM_LO : S_SQRT;
         S_GM_LO: state_in = S_GM_HI;
         S_GM_HI: state_in = S_T_GO;
         S_T_GO:  state_in = S_T_WT;
         S_T_WT:  state_in = div_done ? S_A_GO : S_T_WT;
         S_A_GO:  state_in = S_A_WT;
         S_A_WT:  state_in = div_done ? S_MX_LO : S_A_WT;
         S_MX_LO: state_in = S_MX_HI;
         S_MX_HI: state_in = S_CX_GO;
         S_CX_GO: state_in = S_CX_WT;
         S_CX_WT: state_in = div_done ? S_MY_LO : S_CX_WT;
         S_MY_LO: state_in = S_MY_HI;
         S_MY_HI: state_in = S_CY_GO;
         S_CY_GO: state_in = S_CY_WT;
         S_CY_WT: state_in = div_done ? S_SCAN : S_CY_WT;
         S_FIN_V: state_in = S_FIN_P;
         S_FIN_P: state_in = S_WB;
         S_WB:    state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // unit and memory controls
   always_comb begin
      busy    = state_ff != S_IDLE;
      raddr   = id_ff;
      waddr   = id_ff;
      wr_en   = 1'b0;
      wr_data = '{mass: smass_ff, pos_x: spx_ff, pos_y: spy_ff, vel_x: svx_ff,
                  vel_y: svy_ff, life: life_ff, owner: owner_ff};
      div_go  = 1'b0;
      div_hi  = 32'd0;
      div_lo  = 64'd0;
      mul_a   = adx_ff;
      mul_b   = adx_ff;
      case (state_ff)
         S_IDLE: begin
            raddr   = req_body_id;
            waddr   = req_body_id;
            wr_en   = start && (req_cmd == CMD_ADD) && !req_valid;
            wr_data = '{mass: req_mass, pos_x: req_pos_x, pos_y: req_pos_y,
                        vel_x: req_vel_x, vel_y: req_vel_y, life: req_life,
                        owner: req_owner_id};
         end
         S_SCAN: raddr = j_ff[IDW-1:0];
         S_SQ_Y: begin
            mul_a = ady_ff;
            mul_b = ady_ff;
         end
         S_GM_LO: begin
            mul_a = grav_ff;
            mul_b = mass_ff[31:0];
         end
         S_GM_HI: begin
            mul_a = grav_ff;
            mul_b = {24'd0, mass_ff[39:32]};
         end
         S_T_GO: begin
            div_go = 1'b1;
            div_hi = {15'd0, gm_ff[40:24]};
            div_lo = {gm_ff[23:0], 40'd0};
         end
         S_A_GO: begin
            div_go = 1'b1;
            div_lo = a_ff;
         end
         S_MX_LO: mul_a = a_ff[31:0];
         S_MX_HI: mul_a = a_ff[63:32];
         S_MY_LO: begin
            mul_a = a_ff[31:0];
            mul_b = ady_ff;
         end
         S_MY_HI: begin
            mul_a = a_ff[63:32];
            mul_b = ady_ff;
         end
         S_CX_GO, S_CY_GO: begin
            div_go = 1'b1;
            div_hi = pp_ff[95:64];
            div_lo = pp_ff[63:0];
         end
         S_WB: wr_en = 1'b1;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      valid_in     = valid_ff;
      id_in        = id_ff;
      j_in         = j_ff;
      spx_in       = spx_ff;
      spy_in       = spy_ff;
      svx_in       = svx_ff;
      svy_in       = svy_ff;
      life_in      = life_ff;
      owner_in     = owner_ff;
      smass_in     = smass_ff;
      adx_in       = adx_ff;
      ady_in       = ady_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      mass_in      = mass_ff;
      rad_in       = rad_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      gm_in        = gm_ff;
      a_in         = a_ff;
      pp_in        = pp_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      rsp_valid_in = 1'b0;
      rid_in       = rid_ff;
      rpx_in       = rpx_ff;
      rpy_in       = rpy_ff;
      rvx_in       = rvx_ff;
      rvy_in       = rvy_ff;
      ralive_in    = ralive_ff;
      rowner_in    = rowner_ff;
      rstat_in     = rstat_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               id_in     = req_body_id;
               rid_in    = req_body_id;
               rowner_in = 32'd0;
               if (req_cmd == CMD_ADD && !req_valid) begin
                  valid_in[req_body_id] = 1'b1;
                  rsp_valid_in = 1'b1;
                  rpx_in       = req_pos_x;
                  rpy_in       = req_pos_y;
                  rvx_in       = req_vel_x;
                  rvy_in       = req_vel_y;
                  ralive_in    = 1'b1;
                  rstat_in     = ST_OK;
               end else if (req_cmd == CMD_STEP && !req_valid) begin
                  rsp_valid_in = 1'b1;
                  rpx_in       = 32'sd0;
                  rpy_in       = 32'sd0;
                  rvx_in       = 48'sd0;
                  rvy_in       = 48'sd0;
                  ralive_in    = 1'b0;
                  rstat_in     = ST_NO_BODY;
               end
            end
         end
         S_ADD_RSP: begin
            rsp_valid_in = 1'b1;
            rpx_in       = rd_data.pos_x;
            rpy_in       = rd_data.pos_y;
            rvx_in       = rd_data.vel_x;
            rvy_in       = rd_data.vel_y;
            ralive_in    = 1'b1;
            rstat_in     = ST_OCCUPIED;
         end
         S_SELF: begin
            spx_in   = rd_data.pos_x;
            spy_in   = rd_data.pos_y;
            svx_in   = rd_data.vel_x;
            svy_in   = rd_data.vel_y;
            life_in  = rd_data.life;
            owner_in = rd_data.owner;
            smass_in = rd_data.mass;
            j_in     = '0;
            ax_in    = '0;
            ay_in    = '0;
         end
         S_SCAN: begin
            if (j_ff != (IDW+1)'(MAX_BODIES)) begin
               j_in = j_ff + (IDW+1)'(1);
            end
         end
         S_PAIR: begin
            adx_in  = dx[32] ? 32'(-dx) : dx[31:0];
            ady_in  = dy[32] ? 32'(-dy) : dy[31:0];
            negx_in = dx[32];
            negy_in = dy[32];
            mass_in = rd_data.mass;
         end
         S_SQ_X: rad_in = {2'b00, mul_p};
         S_SQ_Y: begin
            rad_in  = rad_ff + {2'b00, mul_p};
            srem_in = '0;
            root_in = '0;
            cnt_in  = '0;
         end
         S_SQRT: begin
            // one root bit per cycle, two radicand bits in
            rad_in = {rad_ff[63:0], 2'b00};
            cnt_in = cnt_ff + 6'd1;
            if (sq_sh >= sq_trial) begin
               srem_in = sq_sh - sq_trial;
               root_in = {root_ff[31:0], 1'b1};
            end else begin
               srem_in = sq_sh;
               root_in = {root_ff[31:0], 1'b0};
            end
         end
         S_GM_LO: gm_in = {9'd0, mul_p[63:32]};
         S_GM_HI: gm_in = gm_ff + {1'b0, mul_p[39:0]};
         S_T_WT, S_A_WT: begin
            if (div_done) begin
               a_in = div_q;
            end
         end
         S_MX_LO, S_MY_LO: pp_in = {32'd0, mul_p};
         S_MX_HI, S_MY_HI: pp_in = pp_ff + {mul_p, 32'd0};
         S_CX_WT: begin
            if (div_done) begin
               ax_in = acc_add(ax_ff, negx_ff, div_q);
            end
         end
         S_CY_WT: begin
            if (div_done) begin
               ay_in = acc_add(ay_ff, negy_ff, div_q);
            end
         end
         S_FIN_V: begin
            svx_in = (vsx > V_MAX) ? 48'sh7FFF_FFFF_FFFF :
                     (vsx < V_MIN) ? -48'sh8000_0000_0000 : vsx[47:0];
            svy_in = (vsy > V_MAX) ? 48'sh7FFF_FFFF_FFFF :
                     (vsy < V_MIN) ? -48'sh8000_0000_0000 : vsy[47:0];
         end
         S_FIN_P: begin
            spx_in  = (psx > P_MAX) ? 32'sh7FFF_FFFF :
                      (psx < P_MIN) ? -32'sh8000_0000 : psx[31:0];
            spy_in  = (psy > P_MAX) ? 32'sh7FFF_FFFF :
                      (psy < P_MIN) ? -32'sh8000_0000 : psy[31:0];
            life_in = life_ff - 16'd1;
         end
         S_WB: begin
            rsp_valid_in = 1'b1;
            rpx_in       = spx_ff;
            rpy_in       = spy_ff;
            rvx_in       = svx_ff;
            rvy_in       = svy_ff;
            ralive_in    = !dead;
            rowner_in    = dead ? owner_ff : 32'd0;
            rstat_in     = ST_OK;
            if (dead) begin
               valid_in[id_ff] = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         grav_ff      <= GRAV_RESET;
         dt_ff        <= DT_RESET;
         left_ff      <= LEFT_RESET;
         top_ff       <= TOP_RESET;
         right_ff     <= RIGHT_RESET;
         bottom_ff    <= BOTTOM_RESET;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_GRAV:   grav_ff   <= csr_wdata;
               CSR_DT:     dt_ff     <= csr_wdata[7:0];
               CSR_LEFT:   left_ff   <= csr_wdata[15:0];
               CSR_TOP:    top_ff    <= csr_wdata[15:0];
               CSR_RIGHT:  right_ff  <= csr_wdata[15:0];
               CSR_BOTTOM: bottom_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      id_ff     <= id_in;
      j_ff      <= j_in;
      spx_ff    <= spx_in;
      spy_ff    <= spy_in;
      svx_ff    <= svx_in;
      svy_ff    <= svy_in;
      life_ff   <= life_in;
      owner_ff  <= owner_in;
      smass_ff  <= smass_in;
      adx_ff    <= adx_in;
      ady_ff    <= ady_in;
      negx_ff   <= negx_in;
      negy_ff   <= negy_in;
      mass_ff   <= mass_in;
      rad_ff    <= rad_in;
      srem_ff   <= srem_in;
      root_ff   <= root_in;
      cnt_ff    <= cnt_in;
      gm_ff     <= gm_in;
      a_ff      <= a_in;
      pp_ff     <= pp_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      rid_ff    <= rid_in;
      rpx_ff    <= rpx_in;
      rpy_ff    <= rpy_in;
      rvx_ff    <= rvx_in;
      rvy_ff    <= rvy_in;
      ralive_ff <= ralive_in;
      rowner_ff <= rowner_in;
      rstat_ff  <= rstat_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_body_id = rid_ff;
   assign rsp_out_pos_x   = rpx_ff;
   assign rsp_out_pos_y   = rpy_ff;
   assign rsp_out_vel_x   = rvx_ff;
   assign rsp_out_vel_y   = rvy_ff;
   assign rsp_alive       = ralive_ff;
   assign rsp_dead_owner  = rowner_ff;
   assign rsp_status      = rstat_ff;

endmodule
